// ===== hw/rtl/tvrg_pkg.sv =====
// Shared constants, types and state codes for the TV gradient block.
`timescale 1ns / 1ps
package tvrg_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int HIST_DEPTH = 2 * MAX_WIDTH;
  localparam int HIST_ABITS = COL_BITS + 1;
  localparam int PIX_BITS   = 16;
  localparam int WGT_BITS   = 16;
  localparam int HIST_BITS  = PIX_BITS + WGT_BITS;
  localparam int TV_BITS    = 17;
  localparam int DER_BITS   = 24;
  localparam int WREG_BITS  = 11;
  localparam int HREG_BITS  = 16;
  localparam int ROW_BITS   = HREG_BITS + 1;
  localparam int DIF_BITS   = PIX_BITS + 1;
  localparam int N_BITS     = PIX_BITS + 2;
  localparam int MUL_BITS   = WGT_BITS + N_BITS;
  localparam int MOP_BITS   = N_BITS;
  localparam int SQ_BITS    = 2 * PIX_BITS + 2;
  localparam int SQRT_STEPS = SQ_BITS / 2;
  localparam int NUM_BITS   = MUL_BITS + 4;
  localparam int ACC_BITS   = NUM_BITS + 3;
  localparam int STEP_BITS  = 6;

  localparam logic signed [ACC_BITS-1:0] DER_MAX_ACC = ACC_BITS'(2**(DER_BITS-1) - 1);
  localparam logic signed [ACC_BITS-1:0] DER_MIN_ACC = ACC_BITS'(-(2**(DER_BITS-1)));

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_ROUND,
    ST_MUL,
    ST_DIVSET,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;
endpackage

// ===== hw/rtl/tvrg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tvrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/tv_regularizer_gradient.sv =====
// Top level of the weighted isotropic total variation gradient block.
`timescale 1ns / 1ps
// Pixels enter in raster order with a weight each; the result for a pixel comes out one row
// later, so a frame is followed by image_width pad items to drain its last row. Items of the
// first row skip the computation; every other item takes four reads of the
// two-row pixel/weight history RAM, two squaring passes on the shared multiplier, a 17-step
// square root, and three quotient terms, each a multiply and a 38-step divide. A finished
// result waits in the output register while the next item is taken. Writing either
// configuration register restarts the frame.
module tv_regularizer_gradient (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tvrg_pkg::PIX_BITS-1:0]         pixel_value,
  input  logic signed [tvrg_pkg::WGT_BITS-1:0]  weight,
  input  logic                                  is_pad,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tvrg_pkg::DER_BITS-1:0]  derivative,
  output logic [tvrg_pkg::TV_BITS-1:0]          tv_mag,
  output logic                                  last_of_frame,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [tvrg_pkg::HREG_BITS-1:0]        cfg_data
);
  localparam int CB = tvrg_pkg::COL_BITS;
  localparam int PB = tvrg_pkg::PIX_BITS;
  localparam int WB = tvrg_pkg::WGT_BITS;
  localparam int TB = tvrg_pkg::TV_BITS;
  localparam logic [CB:0] COL_ONE = (CB+1)'(1);

  tvrg_pkg::state_t state, state_next;

  logic [tvrg_pkg::WREG_BITS-1:0] width_reg;
  logic [tvrg_pkg::HREG_BITS-1:0] height_reg;
  logic [CB:0]                    col;
  logic [tvrg_pkg::ROW_BITS-1:0]  row;
  logic [TB-1:0]                  tv_left;

  logic [CB:0]                    w_eff;
  logic [tvrg_pkg::HREG_BITS-1:0] h_eff;
  logic                           restart;
  logic [CB:0]                    c0;
  logic [tvrg_pkg::ROW_BITS-1:0]  r0;
  logic                           ignore;
  logic                           accept;

  logic [CB:0]                    it_c;
  logic [tvrg_pkg::ROW_BITS-1:0]  it_r;
  logic                           it_pad;
  logic [PB-1:0]                  it_pix;
  logic signed [WB-1:0]           it_wt;
  logic                           has_result;
  logic                           out_free;

  logic [2:0]                     rd_k;
  logic [PB-1:0]                  xc, xr, xl, xa;
  logic signed [WB-1:0]           wc, wl, wa;
  logic [TB-1:0]                  tv_above;

  logic signed [tvrg_pkg::DIF_BITS-1:0] dx_c, dy_c, dx_r, dy_r, nl_r, na_r;
  logic signed [tvrg_pkg::N_BITS-1:0]   n1_r;

  logic signed [tvrg_pkg::MOP_BITS-1:0]   mult_a, mult_b;
  logic signed [2*tvrg_pkg::MOP_BITS-1:0] mult_p;

  logic [tvrg_pkg::SQ_BITS-1:0]   sv, res, sbit, trial;
  logic [TB-1:0]                  tv;
  logic [tvrg_pkg::STEP_BITS-1:0] step;

  logic [1:0]                     tj;
  logic signed [tvrg_pkg::MUL_BITS-1:0] prod;
  logic [tvrg_pkg::MUL_BITS-1:0]  mag;
  logic                           neg;
  logic [tvrg_pkg::NUM_BITS-1:0]  num;
  logic [TB:0]                    rem;
  logic [TB:0]                    shifted;
  logic [TB-1:0]                  den;
  logic [TB-1:0]                  t_sel;
  logic                           rnd;
  logic [tvrg_pkg::NUM_BITS-1:0]  q;
  logic signed [tvrg_pkg::ACC_BITS-1:0] acc, qx;
  logic signed [tvrg_pkg::ACC_BITS-1:0] acc_sat;
  logic term_en;

  logic                              hist_we, tvm_we;
  logic [tvrg_pkg::HIST_ABITS-1:0]   hist_waddr, hist_raddr;
  logic [tvrg_pkg::HIST_BITS-1:0]    hist_wdata, hist_rdata;
  logic [TB-1:0]                     tvm_rdata;
  logic [CB-1:0]                     cidx;

  tvrg_ram #(.WIDTH(tvrg_pkg::HIST_BITS), .DEPTH(tvrg_pkg::HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  tvrg_ram #(.WIDTH(TB), .DEPTH(tvrg_pkg::MAX_WIDTH)) u_tvrow (
    .clk(clk), .we(tvm_we), .waddr(cidx), .wdata(tv),
    .raddr(cidx), .rdata(tvm_rdata)
  );

  always_comb begin
    if (width_reg == '0) begin
      w_eff = COL_ONE;
    end else if (width_reg > (CB+1)'(tvrg_pkg::MAX_WIDTH)) begin
      w_eff = (CB+1)'(tvrg_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    h_eff   = (height_reg == '0) ? tvrg_pkg::HREG_BITS'(1) : height_reg;
    restart = (col >= w_eff) || (row > {1'b0, h_eff});
    c0      = restart ? '0 : col;
    r0      = restart ? '0 : row;
    ignore  = (r0 != {1'b0, h_eff}) && is_pad;
  end

  assign cidx       = it_c[CB-1:0];
  assign has_result = (it_r != '0);
  assign out_free   = !has_result || !out_valid || out_ready;
  assign accept     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      tvrg_pkg::ST_IDLE: begin
        if (in_valid && !ignore) begin
          state_next = (r0 == '0) ? tvrg_pkg::ST_DONE : tvrg_pkg::ST_READ;
        end
      end
      tvrg_pkg::ST_READ:   if (rd_k == 3'd4) state_next = tvrg_pkg::ST_DIFF;
      tvrg_pkg::ST_DIFF:   state_next = tvrg_pkg::ST_SQ_X;
      tvrg_pkg::ST_SQ_X:   state_next = tvrg_pkg::ST_SQ_Y;
      tvrg_pkg::ST_SQ_Y:   state_next = tvrg_pkg::ST_SQRT;
      tvrg_pkg::ST_SQRT: begin
        if (step == tvrg_pkg::STEP_BITS'(tvrg_pkg::SQRT_STEPS - 1)) begin
          state_next = tvrg_pkg::ST_ROUND;
        end
      end
      tvrg_pkg::ST_ROUND:  state_next = tvrg_pkg::ST_MUL;
      tvrg_pkg::ST_MUL:    state_next = tvrg_pkg::ST_DIVSET;
      tvrg_pkg::ST_DIVSET: state_next = tvrg_pkg::ST_DIV;
      tvrg_pkg::ST_DIV: begin
        if (step == tvrg_pkg::STEP_BITS'(tvrg_pkg::NUM_BITS - 1)) begin
          state_next = tvrg_pkg::ST_ACC;
        end
      end
      tvrg_pkg::ST_ACC:    state_next = (tj == 2'd2) ? tvrg_pkg::ST_DONE : tvrg_pkg::ST_MUL;
      tvrg_pkg::ST_DONE:   if (out_free) state_next = tvrg_pkg::ST_IDLE;
      default:             state_next = tvrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == tvrg_pkg::ST_IDLE);
    hist_we    = (state == tvrg_pkg::ST_DONE) && out_free && !it_pad;
    tvm_we     = (state == tvrg_pkg::ST_DONE) && out_free && has_result;
    hist_waddr = {it_r[0], cidx};
    hist_wdata = {it_pix, it_wt};
    case (rd_k)
      3'd0:    hist_raddr = {~it_r[0], cidx};
      3'd1:    hist_raddr = {~it_r[0], cidx + CB'(1)};
      3'd2:    hist_raddr = {~it_r[0], cidx - CB'(1)};
      default: hist_raddr = {it_r[0], cidx};
    endcase
  end

  always_comb begin
    dx_c = ((it_c + COL_ONE) < w_eff) ?
           $signed({1'b0, xr}) - $signed({1'b0, xc}) : '0;
    dy_c = it_pad ? '0 : $signed({1'b0, it_pix}) - $signed({1'b0, xc});
    case (state)
      tvrg_pkg::ST_SQ_X: begin
        mult_a = tvrg_pkg::MOP_BITS'(dx_r);
        mult_b = tvrg_pkg::MOP_BITS'(dx_r);
      end
      tvrg_pkg::ST_SQ_Y: begin
        mult_a = tvrg_pkg::MOP_BITS'(dy_r);
        mult_b = tvrg_pkg::MOP_BITS'(dy_r);
      end
      default: begin
        case (tj)
          2'd0:    mult_a = tvrg_pkg::MOP_BITS'(wc);
          2'd1:    mult_a = tvrg_pkg::MOP_BITS'(wl);
          default: mult_a = tvrg_pkg::MOP_BITS'(wa);
        endcase
        case (tj)
          2'd0:    mult_b = n1_r;
          2'd1:    mult_b = tvrg_pkg::MOP_BITS'(nl_r);
          default: mult_b = tvrg_pkg::MOP_BITS'(na_r);
        endcase
      end
    endcase
    mult_p = mult_a * mult_b;
    case (tj)
      2'd0:    term_en = 1'b1;
      2'd1:    term_en = (it_c != '0);
      default: term_en = (it_r >= tvrg_pkg::ROW_BITS'(2));
    endcase
    case (tj)
      2'd0:    t_sel = tv;
      2'd1:    t_sel = tv_left;
      default: t_sel = tv_above;
    endcase
    trial   = res + sbit;
    mag     = prod[tvrg_pkg::MUL_BITS-1] ? tvrg_pkg::MUL_BITS'(-prod) : prod;
    shifted = {rem[TB-1:0], num[tvrg_pkg::NUM_BITS-1]};
    rnd     = ({rem, 1'b0} >= {2'b00, den});
    q       = num + tvrg_pkg::NUM_BITS'(rnd);
    qx      = $signed({3'b000, q});
    if (acc > tvrg_pkg::DER_MAX_ACC) begin
      acc_sat = tvrg_pkg::DER_MAX_ACC;
    end else if (acc < tvrg_pkg::DER_MIN_ACC) begin
      acc_sat = tvrg_pkg::DER_MIN_ACC;
    end else begin
      acc_sat = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tvrg_pkg::ST_IDLE;
      width_reg  <= tvrg_pkg::WREG_BITS'(1024);
      height_reg <= tvrg_pkg::HREG_BITS'(1024);
      col        <= '0;
      row        <= '0;
      tv_left    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tvrg_pkg::ST_DONE && out_free && has_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          tvrg_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[tvrg_pkg::WREG_BITS-1:0];
          tvrg_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
        col     <= '0;
        row     <= '0;
        tv_left <= '0;
      end else if (accept) begin
        col <= c0;
        row <= r0;
        if (restart) begin
          tv_left <= '0;
        end
      end else if (state == tvrg_pkg::ST_DONE && out_free) begin
        if ((it_c + COL_ONE) >= w_eff) begin
          col <= '0;
          if ((it_r + tvrg_pkg::ROW_BITS'(1)) > {1'b0, h_eff}) begin
            row     <= '0;
            tv_left <= '0;
          end else begin
            row <= it_r + tvrg_pkg::ROW_BITS'(1);
            if (has_result) begin
              tv_left <= tv;
            end
          end
        end else begin
          col <= it_c + COL_ONE;
          if (has_result) begin
            tv_left <= tv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tvrg_pkg::ST_IDLE: begin
        it_c   <= c0;
        it_r   <= r0;
        it_pad <= (r0 == {1'b0, h_eff});
        it_pix <= pixel_value;
        it_wt  <= weight;
        rd_k   <= '0;
      end
      tvrg_pkg::ST_READ: begin
        rd_k <= rd_k + 3'd1;
        case (rd_k)
          3'd1: begin
            xc       <= hist_rdata[tvrg_pkg::HIST_BITS-1:WB];
            wc       <= hist_rdata[WB-1:0];
            tv_above <= tvm_rdata;
          end
          3'd2: xr <= hist_rdata[tvrg_pkg::HIST_BITS-1:WB];
          3'd3: begin
            xl <= hist_rdata[tvrg_pkg::HIST_BITS-1:WB];
            wl <= hist_rdata[WB-1:0];
          end
          3'd4: begin
            xa <= hist_rdata[tvrg_pkg::HIST_BITS-1:WB];
            wa <= hist_rdata[WB-1:0];
          end
          default: ;
        endcase
      end
      tvrg_pkg::ST_DIFF: begin
        dx_r <= dx_c;
        dy_r <= dy_c;
        n1_r <= tvrg_pkg::N_BITS'(dx_c) + tvrg_pkg::N_BITS'(dy_c);
        nl_r <= $signed({1'b0, xl}) - $signed({1'b0, xc});
        na_r <= $signed({1'b0, xa}) - $signed({1'b0, xc});
      end
      tvrg_pkg::ST_SQ_X: begin
        sv <= mult_p[tvrg_pkg::SQ_BITS-1:0];
      end
      tvrg_pkg::ST_SQ_Y: begin
        sv   <= sv + mult_p[tvrg_pkg::SQ_BITS-1:0];
        res  <= '0;
        sbit <= tvrg_pkg::SQ_BITS'(1) << (tvrg_pkg::SQ_BITS - 2);
        step <= '0;
      end
      tvrg_pkg::ST_SQRT: begin
        if (sv >= trial) begin
          sv  <= sv - trial;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        step <= step + tvrg_pkg::STEP_BITS'(1);
      end
      tvrg_pkg::ST_ROUND: begin
        tv  <= (sv > res) ? TB'(res + tvrg_pkg::SQ_BITS'(1)) : TB'(res);
        tj  <= '0;
        acc <= '0;
      end
      tvrg_pkg::ST_MUL: begin
        prod <= term_en ? mult_p[tvrg_pkg::MUL_BITS-1:0] : '0;
      end
      tvrg_pkg::ST_DIVSET: begin
        neg  <= prod[tvrg_pkg::MUL_BITS-1];
        num  <= {mag, 4'b0000};
        rem  <= '0;
        den  <= (t_sel == '0) ? TB'(1) : t_sel;
        step <= '0;
      end
      tvrg_pkg::ST_DIV: begin
        if (shifted >= {1'b0, den}) begin
          rem <= shifted - {1'b0, den};
          num <= {num[tvrg_pkg::NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted;
          num <= {num[tvrg_pkg::NUM_BITS-2:0], 1'b0};
        end
        step <= step + tvrg_pkg::STEP_BITS'(1);
      end
      tvrg_pkg::ST_ACC: begin
        acc <= neg ? acc - qx : acc + qx;
        tj  <= tj + 2'd1;
      end
      tvrg_pkg::ST_DONE: begin
        if (out_free && has_result) begin
          derivative    <= acc_sat[tvrg_pkg::DER_BITS-1:0];
          tv_mag        <= tv;
          last_of_frame <= it_pad && ((it_c + COL_ONE) == w_eff);
        end
      end
      default: ;
    endcase
  end
endmodule
